@@ hdl/tdbl_pkg.sv @@
package tdbl_pkg;

    localparam int NODE_COUNT  = 1024;
    localparam int LIFT_LEVELS = 10;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int DEPTH_W     = NODE_W;
    localparam int DIST_W      = NODE_W + 1;
    localparam int LEVEL_W     = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int ENTRY_W     = NODE_W + 1;
    localparam int ROW_W       = DEPTH_W + LIFT_LEVELS * ENTRY_W;

    localparam logic [NODE_W-1:0] ROOT_RESET = NODE_W'(1);

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] id;
    } t_entry;

    // One table row per node: its depth and its ancestor at every lifting level.
    typedef struct packed {
        logic [DEPTH_W-1:0]           depth;
        t_entry [LIFT_LEVELS-1:0]     anc;
    } t_row;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_LOAD_X,
        S_LOAD_Y,
        S_SORT,
        S_LIFT,
        S_LIFT_LOAD,
        S_CLIMB,
        S_CLIMB_LA,
        S_CLIMB_LB,
        S_TOP,
        S_TOP_LOAD,
        S_DIST,
        S_ADD_PARENT,
        S_ADD_LEVEL,
        S_ADD_LOAD,
        S_ADD_WRITE,
        S_FINISH
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD_IN,
        OP_START,
        OP_LOAD_X,
        OP_LOAD_Y,
        OP_SORT,
        OP_LIFT,
        OP_LIFT_LOAD,
        OP_CLIMB,
        OP_CLIMB_LA,
        OP_CLIMB_LB,
        OP_TOP,
        OP_TOP_LOAD,
        OP_DIST,
        OP_ADD_PARENT,
        OP_ADD_LEVEL,
        OP_ADD_LOAD,
        OP_ADD_WRITE,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        LVL_HOLD,
        LVL_TOP,
        LVL_ONE,
        LVL_DEC,
        LVL_INC
    } t_lvl_op;

    typedef struct packed {
        t_op     op;
        t_lvl_op lvl_op;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic skip_add;
        logic same_node;
        logic lift_move;
        logic climb_move;
        logic top_valid;
        logic below_valid;
        logic below_self;
        logic lvl_zero;
        logic lvl_last;
        logic clear_done;
        logic out_free;
    } t_status;

endpackage

@@ hdl/tdbl_ram.sv @@
module tdbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/tdbl_ctrl.sv @@
module tdbl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tdbl_pkg::t_status i_status,
    output tdbl_pkg::t_cmd    o_cmd
);

    tdbl_pkg::t_state r_state;
    tdbl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdbl_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.op      = tdbl_pkg::OP_NONE;
        o_cmd.lvl_op  = tdbl_pkg::LVL_HOLD;
        case (r_state)
            tdbl_pkg::S_CLEAR: begin
                o_cmd.op = tdbl_pkg::OP_CLEAR;
                if (i_status.clear_done) begin
                    n_state = tdbl_pkg::S_IDLE;
                end
            end
            tdbl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = tdbl_pkg::OP_LOAD_IN;
                    n_state  = tdbl_pkg::S_START;
                end
            end
            tdbl_pkg::S_START: begin
                o_cmd.op = tdbl_pkg::OP_START;
                if (i_status.is_query) begin
                    n_state = tdbl_pkg::S_LOAD_X;
                end else if (i_status.skip_add) begin
                    n_state = tdbl_pkg::S_FINISH;
                end else begin
                    n_state = tdbl_pkg::S_ADD_PARENT;
                end
            end
            tdbl_pkg::S_LOAD_X: begin
                o_cmd.op = tdbl_pkg::OP_LOAD_X;
                n_state  = tdbl_pkg::S_LOAD_Y;
            end
            tdbl_pkg::S_LOAD_Y: begin
                o_cmd.op = tdbl_pkg::OP_LOAD_Y;
                n_state  = tdbl_pkg::S_SORT;
            end
            tdbl_pkg::S_SORT: begin
                o_cmd.op     = tdbl_pkg::OP_SORT;
                o_cmd.lvl_op = tdbl_pkg::LVL_TOP;
                n_state      = i_status.same_node ? tdbl_pkg::S_DIST : tdbl_pkg::S_LIFT;
            end
            tdbl_pkg::S_LIFT: begin
                o_cmd.op = tdbl_pkg::OP_LIFT;
                if (i_status.lift_move) begin
                    n_state = tdbl_pkg::S_LIFT_LOAD;
                end else if (i_status.lvl_zero) begin
                    o_cmd.lvl_op = tdbl_pkg::LVL_TOP;
                    n_state      = tdbl_pkg::S_CLIMB;
                end else begin
                    o_cmd.lvl_op = tdbl_pkg::LVL_DEC;
                end
            end
            tdbl_pkg::S_LIFT_LOAD: begin
                o_cmd.op = tdbl_pkg::OP_LIFT_LOAD;
                if (i_status.same_node) begin
                    n_state = tdbl_pkg::S_DIST;
                end else if (i_status.lvl_zero) begin
                    o_cmd.lvl_op = tdbl_pkg::LVL_TOP;
                    n_state      = tdbl_pkg::S_CLIMB;
                end else begin
                    o_cmd.lvl_op = tdbl_pkg::LVL_DEC;
                    n_state      = tdbl_pkg::S_LIFT;
                end
            end
            tdbl_pkg::S_CLIMB: begin
                o_cmd.op = tdbl_pkg::OP_CLIMB;
                if (i_status.climb_move) begin
                    n_state = tdbl_pkg::S_CLIMB_LA;
                end else if (i_status.lvl_zero) begin
                    n_state = tdbl_pkg::S_TOP;
                end else begin
                    o_cmd.lvl_op = tdbl_pkg::LVL_DEC;
                end
            end
            tdbl_pkg::S_CLIMB_LA: begin
                o_cmd.op = tdbl_pkg::OP_CLIMB_LA;
                n_state  = tdbl_pkg::S_CLIMB_LB;
            end
            tdbl_pkg::S_CLIMB_LB: begin
                o_cmd.op = tdbl_pkg::OP_CLIMB_LB;
                if (i_status.lvl_zero) begin
                    n_state = tdbl_pkg::S_TOP;
                end else begin
                    o_cmd.lvl_op = tdbl_pkg::LVL_DEC;
                    n_state      = tdbl_pkg::S_CLIMB;
                end
            end
            tdbl_pkg::S_TOP: begin
                o_cmd.op = tdbl_pkg::OP_TOP;
                n_state  = i_status.top_valid ? tdbl_pkg::S_TOP_LOAD : tdbl_pkg::S_FINISH;
            end
            tdbl_pkg::S_TOP_LOAD: begin
                o_cmd.op = tdbl_pkg::OP_TOP_LOAD;
                n_state  = tdbl_pkg::S_DIST;
            end
            tdbl_pkg::S_DIST: begin
                o_cmd.op = tdbl_pkg::OP_DIST;
                n_state  = tdbl_pkg::S_FINISH;
            end
            tdbl_pkg::S_ADD_PARENT: begin
                o_cmd.op     = tdbl_pkg::OP_ADD_PARENT;
                o_cmd.lvl_op = tdbl_pkg::LVL_ONE;
                n_state      = (tdbl_pkg::LIFT_LEVELS > 1) ? tdbl_pkg::S_ADD_LEVEL
                                                           : tdbl_pkg::S_ADD_WRITE;
            end
            tdbl_pkg::S_ADD_LEVEL: begin
                o_cmd.op = tdbl_pkg::OP_ADD_LEVEL;
                if (!i_status.below_valid) begin
                    n_state = tdbl_pkg::S_ADD_WRITE;
                end else if (i_status.below_self) begin
                    // The entry below is the node itself, so the new entry is taken
                    // from the row under construction without a table read.
                    if (i_status.lvl_last) begin
                        n_state = tdbl_pkg::S_ADD_WRITE;
                    end else begin
                        o_cmd.lvl_op = tdbl_pkg::LVL_INC;
                    end
                end else begin
                    n_state = tdbl_pkg::S_ADD_LOAD;
                end
            end
            tdbl_pkg::S_ADD_LOAD: begin
                o_cmd.op = tdbl_pkg::OP_ADD_LOAD;
                if (i_status.lvl_last) begin
                    n_state = tdbl_pkg::S_ADD_WRITE;
                end else begin
                    o_cmd.lvl_op = tdbl_pkg::LVL_INC;
                    n_state      = tdbl_pkg::S_ADD_LEVEL;
                end
            end
            tdbl_pkg::S_ADD_WRITE: begin
                o_cmd.op = tdbl_pkg::OP_ADD_WRITE;
                n_state  = tdbl_pkg::S_FINISH;
            end
            tdbl_pkg::S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.op = tdbl_pkg::OP_OUT;
                    n_state  = tdbl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tdbl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/tdbl_dp.sv @@
module tdbl_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tdbl_pkg::NODE_W-1:0]   i_cfg_wdata,
    input  logic                          i_req_type,
    input  logic [tdbl_pkg::NODE_W-1:0]   i_first_node,
    input  logic [tdbl_pkg::NODE_W-1:0]   i_second_node,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [tdbl_pkg::DIST_W-1:0]   o_path_length,
    output logic [tdbl_pkg::NODE_W-1:0]   o_common_ancestor,
    output logic                          o_is_query_answer,
    input  tdbl_pkg::t_cmd                i_cmd,
    output tdbl_pkg::t_status             o_status
);

    localparam int NW = tdbl_pkg::NODE_W;
    localparam int LW = tdbl_pkg::LEVEL_W;
    localparam int DW = tdbl_pkg::DEPTH_W;

    // Control state.
    logic [NW-1:0]         r_clr;
    logic [NW-1:0]         r_root;
    logic                  r_o_valid;

    // Item state.
    logic                  r_req;
    logic [NW-1:0]         r_x;
    logic [NW-1:0]         r_y;
    logic [NW-1:0]         r_a;
    logic [NW-1:0]         r_b;
    tdbl_pkg::t_row        r_ra;
    tdbl_pkg::t_row        r_rb;
    tdbl_pkg::t_row        r_nrow;
    logic [DW-1:0]         r_diff;
    logic [DW:0]           r_dsum;
    logic [DW-1:0]         r_dl;
    logic [LW-1:0]         r_lvl;
    logic [NW-1:0]         r_lca;
    logic [tdbl_pkg::DIST_W-1:0] r_len;
    logic [tdbl_pkg::DIST_W-1:0] r_o_len;
    logic [NW-1:0]         r_o_anc;
    logic                  r_o_isq;

    // Table port.
    logic                  w_we;
    logic [NW-1:0]         w_waddr;
    tdbl_pkg::t_row        w_wdata;
    logic [NW-1:0]         w_raddr;
    logic [tdbl_pkg::ROW_W-1:0] w_rdata;
    tdbl_pkg::t_row        w_q;

    tdbl_pkg::t_entry      w_ea;
    tdbl_pkg::t_entry      w_eb;
    tdbl_pkg::t_entry      w_top;
    tdbl_pkg::t_entry      w_below;
    logic [LW-1:0]         w_lvl_m1;
    logic                  w_swap;
    logic                  w_out_free;
    logic [DW:0]           w_twice_dl;

    tdbl_ram #(
        .WIDTH (tdbl_pkg::ROW_W),
        .DEPTH (tdbl_pkg::NODE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_q        = w_rdata;
    assign w_lvl_m1   = r_lvl - LW'(1);
    assign w_ea       = r_ra.anc[r_lvl];
    assign w_eb       = r_rb.anc[r_lvl];
    assign w_top      = r_ra.anc[0];
    assign w_below    = r_nrow.anc[w_lvl_m1];
    assign w_swap     = r_ra.depth < r_rb.depth;
    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_twice_dl = {r_dl, 1'b0};

    always_comb begin
        o_status.is_query    = r_req;
        o_status.skip_add    = (r_x == r_root) || (r_x == r_y);
        o_status.same_node   = (r_a == r_b);
        o_status.lift_move   = r_diff[r_lvl] && w_ea.valid;
        o_status.climb_move  = w_ea.valid && w_eb.valid && (w_ea.id != w_eb.id);
        o_status.top_valid   = w_top.valid;
        o_status.below_valid = w_below.valid;
        o_status.below_self  = (w_below.id == r_x);
        o_status.lvl_zero    = (r_lvl == '0);
        o_status.lvl_last    = (r_lvl == LW'(tdbl_pkg::LIFT_LEVELS - 1));
        o_status.clear_done  = &r_clr;
        o_status.out_free    = w_out_free;
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_x;
        w_wdata = r_nrow;
        w_raddr = '0;
        case (i_cmd.op)
            tdbl_pkg::OP_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            tdbl_pkg::OP_START:     w_raddr = r_req ? r_x : r_y;
            tdbl_pkg::OP_LOAD_X:    w_raddr = r_y;
            tdbl_pkg::OP_LIFT:      w_raddr = w_ea.id;
            tdbl_pkg::OP_CLIMB:     w_raddr = w_ea.id;
            tdbl_pkg::OP_CLIMB_LA:  w_raddr = r_b;
            tdbl_pkg::OP_TOP:       w_raddr = w_top.id;
            tdbl_pkg::OP_ADD_LEVEL: w_raddr = w_below.id;
            tdbl_pkg::OP_ADD_WRITE: w_we    = 1'b1;
            default: begin
                w_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_root    <= tdbl_pkg::ROOT_RESET;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.op == tdbl_pkg::OP_CLEAR) begin
                r_clr <= r_clr + NW'(1);
            end
            if (i_cfg_we) begin
                r_root <= i_cfg_wdata;
            end
            if (i_cmd.op == tdbl_pkg::OP_OUT) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.lvl_op)
            tdbl_pkg::LVL_TOP: r_lvl <= LW'(tdbl_pkg::LIFT_LEVELS - 1);
            tdbl_pkg::LVL_ONE: r_lvl <= LW'(1);
            tdbl_pkg::LVL_DEC: r_lvl <= r_lvl - LW'(1);
            tdbl_pkg::LVL_INC: r_lvl <= r_lvl + LW'(1);
            default: begin
                r_lvl <= r_lvl;
            end
        endcase

        case (i_cmd.op)
            tdbl_pkg::OP_LOAD_IN: begin
                r_req <= i_req_type;
                r_x   <= i_first_node;
                r_y   <= i_second_node;
            end
            tdbl_pkg::OP_START: begin
                r_len <= '0;
                r_lca <= '0;
            end
            tdbl_pkg::OP_LOAD_X: begin
                r_ra <= w_q;
                r_a  <= r_x;
            end
            tdbl_pkg::OP_LOAD_Y: begin
                r_rb <= w_q;
                r_b  <= r_y;
            end
            tdbl_pkg::OP_SORT: begin
                // Put the deeper node in the a slot.
                if (w_swap) begin
                    r_a    <= r_b;
                    r_b    <= r_a;
                    r_ra   <= r_rb;
                    r_rb   <= r_ra;
                    r_diff <= r_rb.depth - r_ra.depth;
                end else begin
                    r_diff <= r_ra.depth - r_rb.depth;
                end
                r_dsum <= {1'b0, r_ra.depth} + {1'b0, r_rb.depth};
                if (r_a == r_b) begin
                    r_lca <= r_a;
                    r_dl  <= r_ra.depth;
                end
            end
            tdbl_pkg::OP_LIFT: begin
                if (r_diff[r_lvl] && w_ea.valid) begin
                    r_a <= w_ea.id;
                end
            end
            tdbl_pkg::OP_LIFT_LOAD: begin
                r_ra <= w_q;
                if (r_a == r_b) begin
                    r_lca <= r_a;
                    r_dl  <= w_q.depth;
                end
            end
            tdbl_pkg::OP_CLIMB: begin
                if (w_ea.valid && w_eb.valid && (w_ea.id != w_eb.id)) begin
                    r_a <= w_ea.id;
                    r_b <= w_eb.id;
                end
            end
            tdbl_pkg::OP_CLIMB_LA: r_ra <= w_q;
            tdbl_pkg::OP_CLIMB_LB: r_rb <= w_q;
            tdbl_pkg::OP_TOP: begin
                if (w_top.valid) begin
                    r_lca <= w_top.id;
                end
            end
            tdbl_pkg::OP_TOP_LOAD: r_dl <= w_q.depth;
            tdbl_pkg::OP_DIST: begin
                // A negative distance can only come from inconsistent tables; it reads as zero.
                r_len <= (r_dsum >= w_twice_dl) ? (r_dsum - w_twice_dl) : '0;
            end
            tdbl_pkg::OP_ADD_PARENT: begin
                // Level zero names the parent; the levels above start out empty.
                r_nrow <= {(&w_q.depth) ? w_q.depth : w_q.depth + DW'(1),
                           {((tdbl_pkg::LIFT_LEVELS - 1) * tdbl_pkg::ENTRY_W){1'b0}},
                           1'b1, r_y};
            end
            tdbl_pkg::OP_ADD_LEVEL: begin
                if (w_below.valid && (w_below.id == r_x)) begin
                    r_nrow.anc[r_lvl] <= w_below;
                end
            end
            tdbl_pkg::OP_ADD_LOAD: r_nrow.anc[r_lvl] <= w_q.anc[w_lvl_m1];
            tdbl_pkg::OP_OUT: begin
                r_o_len <= r_len;
                r_o_anc <= r_lca;
                r_o_isq <= r_req;
            end
            default: begin
                r_req <= r_req;
            end
        endcase
    end

    assign o_out_valid       = r_o_valid;
    assign o_path_length     = r_o_len;
    assign o_common_ancestor = r_o_anc;
    assign o_is_query_answer = r_o_isq;

    a_sort_deeper_first: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == tdbl_pkg::OP_SORT) |=> (r_ra.depth >= r_rb.depth)
    ) else $error("deeper node not in the a slot after sorting");

    a_add_result_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == tdbl_pkg::OP_OUT && !r_req) |=>
            (r_o_len == '0 && r_o_anc == '0 && !r_o_isq)
    ) else $error("add acknowledgement carries a nonzero answer");

    a_add_row_parent: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == tdbl_pkg::OP_ADD_WRITE) |->
            (r_nrow.anc[0].valid && r_nrow.anc[0].id == r_y && r_x != r_root)
    ) else $error("written row does not name the parent at the lowest level");

endmodule

@@ hdl/tree_distance_binary_lifting.sv @@
// Add: an ignored add goes straight to the result; otherwise the new row is filled level
// by level, with one table read for each level whose entry is not taken from the row itself.
// Query: the lift and the joint climb walk the levels over the single read port of the node table.
// One item is in work at a time; a new item is taken while the last result waits.
// Reset (synchronous, active low) clears the node table, all 1024 rows; inputs wait.
module tree_distance_binary_lifting (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tdbl_pkg::NODE_W-1:0]   i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [tdbl_pkg::NODE_W-1:0]   i_first_node,
    input  logic [tdbl_pkg::NODE_W-1:0]   i_second_node,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tdbl_pkg::DIST_W-1:0]   o_path_length,
    output logic [tdbl_pkg::NODE_W-1:0]   o_common_ancestor,
    output logic                          o_is_query_answer
);

    tdbl_pkg::t_cmd    w_cmd;
    tdbl_pkg::t_status w_status;

    tdbl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tdbl_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_req_type        (i_req_type),
        .i_first_node      (i_first_node),
        .i_second_node     (i_second_node),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_path_length     (o_path_length),
        .o_common_ancestor (o_common_ancestor),
        .o_is_query_answer (o_is_query_answer),
        .i_cmd             (w_cmd),
        .o_status          (w_status)
    );

endmodule
